// ----- rtl/hrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_pkg: shared types and constants for the haversine radius check
// Fixed-point formats, angle reduction constants and CORDIC tables.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    // angle in half-microdegrees
    localparam int ANG_W = 30;
    // width used for exact modular reduction
    localparam int RED_W = 31;
    // folded magnitude, at most a quarter turn
    localparam int MAG_W = 28;
    // sine / cosine / vectoring x,y (Q30, signed)
    localparam int CS_W  = 33;
    // CORDIC angles (Q29, signed)
    localparam int Z_W   = 33;

    localparam logic signed [RED_W-1:0] UNITS_FULL    = 31'sd720000000;
    localparam logic signed [RED_W-1:0] UNITS_HALF    = 31'sd360000000;
    localparam logic signed [RED_W-1:0] UNITS_QUARTER = 31'sd180000000;

    // radians per half-microdegree, scaled by 2^61, split for two products
    localparam logic [34:0] RAD_SCALE = 35'd20122276272;
    localparam int          RAD_LO_W  = 18;
    localparam int          RAD_HI_W  = 35 - RAD_LO_W;
    localparam logic [RAD_HI_W-1:0] RAD_HI = RAD_SCALE[34:RAD_LO_W];
    localparam logic [RAD_LO_W-1:0] RAD_LO = RAD_SCALE[RAD_LO_W-1:0];

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [CS_W-1:0] ONE_Q30         = 33'sd1073741824;

    // integer square root of a 61-bit value, one result bit per step
    localparam int SQ_IN_W  = 61;
    localparam int SQ_N_W   = 62;
    localparam int SQ_STEPS = 31;
    localparam int SQ_OUT_W = 31;

    localparam int          DIAM_W     = 24;
    localparam logic [DIAM_W-1:0] EARTH_DIAM_M = 24'd12742000;
    localparam int          DIST_W     = 25;
    localparam int          DPROD_W    = 56;

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic signed [CS_W-1:0]  t_trig;
    typedef logic signed [Z_W-1:0]   t_zang;

    function automatic t_zang atan_q29(input int i);
        t_zang r;
        unique case (i)
            0:  r = 33'sd421657428;
            1:  r = 33'sd248918915;
            2:  r = 33'sd131521918;
            3:  r = 33'sd66762579;
            4:  r = 33'sd33510843;
            5:  r = 33'sd16771758;
            6:  r = 33'sd8387925;
            7:  r = 33'sd4194219;
            8:  r = 33'sd2097141;
            9:  r = 33'sd1048575;
            10: r = 33'sd524288;
            default: begin
                if (i <= 29) r = t_zang'(33'sd1 <<< (29 - i));
                else r = '0;
            end
        endcase
        return r;
    endfunction

    // Q30 product, rounded half away from zero
    function automatic t_trig mul_q30(input t_trig a, input t_trig b);
        logic        neg;
        logic [CS_W-1:0] ua;
        logic [CS_W-1:0] ub;
        logic [63:0] p;
        t_trig       r;
        neg = a[CS_W-1] ^ b[CS_W-1];
        ua  = a[CS_W-1] ? -a : a;
        ub  = b[CS_W-1] ? -b : b;
        p   = (64'(ua[31:0]) * 64'(ub[31:0]) + (64'd1 << 29)) >> 30;
        r   = t_trig'(p[CS_W-1:0]);
        return neg ? -r : r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/haversine_radius_check_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_radius_check_core: great-circle distance and radius test
// Streams point pairs in, distance in meters and a within-radius flag out.
// ----------------------------------------------------------------------------
// Fully pipelined: one point pair per clock while the output is not stalled.
// The depth comes from four parallel rotation CORDIC units, two 31-step
// square-root pipelines and one vectoring CORDIC, each one iteration per
// stage. A stall on the output freezes the whole pipeline; no transaction
// is dropped or duplicated. The radius register sits at byte address 0.
module haversine_radius_check_core #(
    parameter int CORDIC_STAGES = hrc_pkg::CORDIC_STAGES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave stream
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [27:0] first_lat, [56:28] first_lon, [84:57] second_lat,
    // [113:85] second_lon, [119:114] zero
    input  wire  [119:0] i_s_axis_tdata,
    // master stream
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [24:0] distance_m, [25] within_res, [31:26] zero
    output logic [31:0]  o_m_axis_tdata,
    // config
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hrc_pkg::*;

    localparam int          LAT        = 2 * CORDIC_STAGES + 43;
    localparam int          A_VLD      = CORDIC_STAGES + 7;
    localparam logic        REG_RADIUS = 1'b0;
    localparam logic [DIST_W-1:0] RADIUS_RST = 25'd5000;

    logic              en;
    logic [LAT-1:0]    r_vld;
    logic [DIST_W-1:0] r_radius;

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS) begin
            r_radius <= pwdata[DIST_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(r_radius) : '0;

    // ---------------- flow control ----------------
    assign en              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // ---------------- angles ----------------
    t_angle r_dlat, r_dlon, r_lat1x2, r_lat2x2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // half-microdegree units: half differences are the plain differences
            r_dlat   <= t_angle'($signed(i_s_axis_tdata[84:57]))
                      - t_angle'($signed(i_s_axis_tdata[27:0]));
            r_dlon   <= t_angle'($signed(i_s_axis_tdata[113:85]))
                      - t_angle'($signed(i_s_axis_tdata[56:28]));
            r_lat1x2 <= t_angle'($signed(i_s_axis_tdata[27:0])) <<< 1;
            r_lat2x2 <= t_angle'($signed(i_s_axis_tdata[84:57])) <<< 1;
        end
    end

    t_trig s_lat, c_lat, s_lon, c_lon, s1, c1, s2, c2;

    hrc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
        .i_clk(i_clk), .i_en(en), .i_angle(r_dlat), .o_sin(s_lat), .o_cos(c_lat));
    hrc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
        .i_clk(i_clk), .i_en(en), .i_angle(r_dlon), .o_sin(s_lon), .o_cos(c_lon));
    hrc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
        .i_clk(i_clk), .i_en(en), .i_angle(r_lat1x2), .o_sin(s1), .o_cos(c1));
    hrc_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
        .i_clk(i_clk), .i_en(en), .i_angle(r_lat2x2), .o_sin(s2), .o_cos(c2));

    // ---------------- haversine term ----------------
    t_trig               r_sq_lat, r_sq_lon, r_cc, r_sq_lat2, r_term;
    logic [SQ_OUT_W-1:0] r_a;
    t_trig               n_a;

    always_comb begin
        n_a = r_sq_lat2 + r_term;
        if (n_a[CS_W-1]) n_a = '0;
        else if (n_a > ONE_Q30) n_a = ONE_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_lat  <= mul_q30(s_lat, s_lat);
            r_sq_lon  <= mul_q30(s_lon, s_lon);
            r_cc      <= mul_q30(c1, c2);
            r_sq_lat2 <= r_sq_lat;
            r_term    <= mul_q30(r_cc, r_sq_lon);
            r_a       <= n_a[SQ_OUT_W-1:0];
        end
    end

    // ---------------- square roots ----------------
    logic [SQ_OUT_W-1:0] root_a, root_b;
    logic [SQ_OUT_W-1:0] one_minus_a;

    assign one_minus_a = ONE_Q30[SQ_OUT_W-1:0] - r_a;

    hrc_isqrt u_sqrt_a (
        .i_clk(i_clk), .i_en(en), .i_n({r_a, 30'd0}), .o_root(root_a));
    hrc_isqrt u_sqrt_b (
        .i_clk(i_clk), .i_en(en), .i_n({one_minus_a, 30'd0}), .o_root(root_b));

    // ---------------- atan2 by vectoring ----------------
    t_trig r_vx [0:CORDIC_STAGES];
    t_trig r_vy [0:CORDIC_STAGES];
    t_zang r_vz [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx[0] <= t_trig'({2'b00, root_b});
            r_vy[0] <= t_trig'({2'b00, root_a});
            r_vz[0] <= '0;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                if (!r_vy[k][CS_W-1] && r_vy[k] != '0) begin
                    r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] + atan_q29(k);
                end else begin
                    r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] - atan_q29(k);
                end
            end
        end
    end

    // ---------------- distance ----------------
    logic [DPROD_W-1:0] r_dprod;
    logic [DIST_W-1:0]  r_dist;
    logic               r_within;
    logic [31:0]        z_pos;
    logic [DPROD_W-1:0] d_round;
    logic [DIST_W-1:0]  d_sat;

    assign z_pos   = r_vz[CORDIC_STAGES][Z_W-1] ? '0 : r_vz[CORDIC_STAGES][31:0];
    assign d_round = (r_dprod + (DPROD_W'(1) << 28)) >> 29;
    assign d_sat   = (d_round > DPROD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                          : d_round[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dprod  <= DPROD_W'(z_pos) * DPROD_W'(EARTH_DIAM_M);
            r_dist   <= d_sat;
            r_within <= (d_sat <= r_radius);
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {6'd0, r_within, r_dist};

    // ---------------- checks ----------------
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid pipeline moved during stall");

    a_term_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[A_VLD] |-> (r_a <= ONE_Q30[SQ_OUT_W-1:0]))
        else $error("haversine term out of range");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_dist <= 25'd20100000))
        else $error("distance beyond half circumference");

endmodule
`default_nettype wire

// ----- rtl/hrc_sincos.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_sincos: pipelined sine and cosine
// Exact reduction of a half-microdegree angle, conversion to Q3.29 radians,
// then one rotation CORDIC iteration per register stage.
// ----------------------------------------------------------------------------
module hrc_sincos #(
    parameter int STAGES = hrc_pkg::CORDIC_STAGES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  hrc_pkg::t_angle     i_angle,
    output hrc_pkg::t_trig      o_sin,
    output hrc_pkg::t_trig      o_cos
);
    import hrc_pkg::*;

    // stage A: reduce and fold
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg_a;
    logic                      r_flip_a;
    // stage B: partial products
    logic [MAG_W+RAD_HI_W-1:0] r_phi;
    logic [MAG_W+RAD_LO_W-1:0] r_plo;
    logic                      r_neg_b;
    logic                      r_flip_b;
    // CORDIC stages, index 0 is the start vector
    t_trig                     r_x [0:STAGES];
    t_trig                     r_y [0:STAGES];
    t_zang                     r_z [0:STAGES];
    logic                      r_flip [0:STAGES];
    t_trig                     r_sin;
    t_trig                     r_cos;

    logic signed [RED_W-1:0]   n_red;
    logic signed [RED_W-1:0]   n_fold;
    logic                      n_flip;
    logic [63:0]               n_sum;
    t_zang                     n_z;

    always_comb begin
        n_red = RED_W'(i_angle);
        if (n_red > UNITS_HALF) n_red = n_red - UNITS_FULL;
        else if (n_red <= -UNITS_HALF) n_red = n_red + UNITS_FULL;
        n_fold = n_red;
        n_flip = 1'b0;
        // beyond a quarter turn: mirror, cosine changes sign
        if (n_red > UNITS_QUARTER) begin
            n_fold = UNITS_HALF - n_red;
            n_flip = 1'b1;
        end else if (n_red < -UNITS_QUARTER) begin
            n_fold = -UNITS_HALF - n_red;
            n_flip = 1'b1;
        end
    end

    always_comb begin
        n_sum = (64'(r_phi) << RAD_LO_W) + 64'(r_plo) + (64'd1 << 31);
        n_z   = t_zang'({2'b00, n_sum[62:32]});
        if (r_neg_b) n_z = -n_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= n_fold[RED_W-1] ? MAG_W'(-n_fold) : MAG_W'(n_fold);
            r_neg_a  <= n_fold[RED_W-1];
            r_flip_a <= n_flip;

            r_phi    <= (MAG_W+RAD_HI_W)'(r_mag) * (MAG_W+RAD_HI_W)'(RAD_HI);
            r_plo    <= (MAG_W+RAD_LO_W)'(r_mag) * (MAG_W+RAD_LO_W)'(RAD_LO);
            r_neg_b  <= r_neg_a;
            r_flip_b <= r_flip_a;

            r_x[0]    <= CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= r_flip_b;

            for (int k = 0; k < STAGES; k++) begin
                if (!r_z[k][Z_W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q29(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q29(k);
                end
                r_flip[k+1] <= r_flip[k];
            end

            r_sin <= r_y[STAGES];
            r_cos <= r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// ----- rtl/hrc_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_isqrt: pipelined floor integer square root
// Input register plus one restoring step per stage.
// ----------------------------------------------------------------------------
module hrc_isqrt (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [hrc_pkg::SQ_IN_W-1:0]   i_n,
    output logic [hrc_pkg::SQ_OUT_W-1:0] o_root
);
    import hrc_pkg::*;

    logic [SQ_N_W-1:0] r_n [0:SQ_STEPS];
    logic [SQ_N_W-1:0] r_r [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        logic [SQ_N_W-1:0] bitv;
        logic [SQ_N_W-1:0] trial;
        if (i_en) begin
            r_n[0] <= SQ_N_W'(i_n);
            r_r[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                bitv  = SQ_N_W'(1) << (2 * (SQ_STEPS - 1 - k));
                trial = r_r[k] + bitv;
                if (r_n[k] >= trial) begin
                    r_n[k+1] <= r_n[k] - trial;
                    r_r[k+1] <= (r_r[k] >> 1) + bitv;
                end else begin
                    r_n[k+1] <= r_n[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQ_STEPS][SQ_OUT_W-1:0];

endmodule
`default_nettype wire
